>>> hdl/grt_pkg.sv
// ============================================================================
// grt_pkg
// Shared widths, types and register indexes of the grid ray traversal block.
// ============================================================================
`default_nettype none

package grt_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int INDEX_WIDTH     = 16;
    localparam int DIST_WIDTH      = 48;
    localparam int DIR_WIDTH       = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [INDEX_WIDTH-1:0] index_t;
    typedef logic signed [DIST_WIDTH-1:0]  dist_t;
    typedef logic signed [DIR_WIDTH-1:0]   dir_t;
    typedef logic [CFG_WIDTH-1:0]          cfg_word_t;
    typedef logic [CFG_INDEX_WIDTH-1:0]    cfg_index_t;

    localparam dist_t DIST_MAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};
    localparam dist_t DIST_MIN = {1'b1, {(DIST_WIDTH-1){1'b0}}};

    // Configuration register indexes.
    localparam cfg_index_t CFG_CELL_SIZE   = 3'd0;
    localparam cfg_index_t CFG_INDEX_X_MIN = 3'd1;
    localparam cfg_index_t CFG_INDEX_X_MAX = 3'd2;
    localparam cfg_index_t CFG_INDEX_Y_MIN = 3'd3;
    localparam cfg_index_t CFG_INDEX_Y_MAX = 3'd4;

    // Command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

endpackage

`default_nettype wire

>>> hdl/grid_ray_traversal.sv
// ============================================================================
// grid_ray_traversal
// Steps a ray through a 2D grid of square cells, at most one cell crossing per step.
// ============================================================================
// Usage: an input transfer carries a command. A start command (cmd 0) takes
// the start point, start cell and direction; the block normalizes the
// direction and sets up per-axis crossing and boundary distances. A step
// command (cmd 1) moves to the next cell along the ray. Every command gives
// exactly one result transfer with the current cell, its inside flag, the
// current point and the previous point.
// Latency: a step result is valid the cycle after its transfer; steps may
// follow each other every cycle while results are taken. A start runs 30
// square-root iterations and six 64-iteration divisions (unit direction,
// crossing and boundary distance per axis) through one shared
// subtract-and-compare unit; a frozen axis skips its distance divisions.
// in_ready is low while a start is being worked on and while a finished
// result waits on a stalled receiver; the result is held until taken.
// Configuration writes are taken every cycle (cfg_ready is always high).
// Reset restores the default configuration and a frozen ray at cell (0,0).
// ============================================================================
`default_nettype none

module grid_ray_traversal (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire grt_pkg::cfg_index_t cfg_index,
    input  wire grt_pkg::cfg_word_t  cfg_data,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire                      cmd,
    input  wire grt_pkg::coord_t     start_x,
    input  wire grt_pkg::coord_t     start_y,
    input  wire grt_pkg::index_t     start_cell_x,
    input  wire grt_pkg::index_t     start_cell_y,
    input  wire grt_pkg::dir_t       dir_x,
    input  wire grt_pkg::dir_t       dir_y,
    output logic                     out_valid,
    input  wire                      out_ready,
    output grt_pkg::index_t          cell_x,
    output grt_pkg::index_t          cell_y,
    output logic                     inside_res,
    output grt_pkg::coord_t          point_x,
    output grt_pkg::coord_t          point_y,
    output grt_pkg::coord_t          prev_x,
    output grt_pkg::coord_t          prev_y
);
    import grt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULX  = 4'd1;
    localparam logic [3:0] S_MULY  = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_ULOAD = 4'd4;
    localparam logic [3:0] S_UDIV  = 4'd5;
    localparam logic [3:0] S_UFIN  = 4'd6;
    localparam logic [3:0] S_MADV  = 4'd7;
    localparam logic [3:0] S_MBND  = 4'd8;
    localparam logic [3:0] S_CDIV  = 4'd9;
    localparam logic [3:0] S_BDIV  = 4'd10;
    localparam logic [3:0] S_BFIN  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    localparam logic [5:0] SQRT_LAST = 6'd29;
    localparam logic [5:0] DIV_LAST  = 6'd63;

    // Control and sequencing.
    logic [3:0]  state_reg, state_next;
    logic        axis_reg, axis_next;
    logic [5:0]  cnt_reg, cnt_next;
    // Shared iterative unit: shift register, partial remainder, root.
    logic [63:0] sh_reg, sh_next;
    logic [33:0] rem_reg, rem_next;
    logic [29:0] root_reg, root_next;
    logic [31:0] sq_reg, sq_next;
    logic [15:0] um_reg, um_next;
    logic        mneg_reg, mneg_next;
    logic [40:0] mmag_reg, mmag_next;
    dir_t        dir_reg [2];
    dir_t        dir_next [2];

    // Ray state.
    dir_t        unit_reg [2];
    dir_t        unit_next [2];
    logic [47:0] cross_reg [2];
    logic [47:0] cross_next [2];
    dist_t       bnd_reg [2];
    dist_t       bnd_next [2];
    coord_t      adv_reg [2];
    coord_t      adv_next [2];
    index_t      cell_reg [2];
    index_t      cell_next [2];
    coord_t      pnt_reg [2];
    coord_t      pnt_next [2];
    coord_t      prv_reg [2];
    coord_t      prv_next [2];

    // Configuration.
    logic [15:0] cs_reg, cs_next;
    index_t      xmin_reg, xmin_next;
    index_t      xmax_reg, xmax_next;
    index_t      ymin_reg, ymin_next;
    index_t      ymax_reg, ymax_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    index_t      ocx_reg, ocx_next;
    index_t      ocy_reg, ocy_next;
    logic        oin_reg, oin_next;
    coord_t      opx_reg, opx_next;
    coord_t      opy_reg, opy_next;
    coord_t      oqx_reg, oqx_next;
    coord_t      oqy_reg, oqy_next;

    // Shared multiplier.
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] prod;

    // Shared subtract-and-compare step.
    logic        is_sqrt;
    logic [29:0] div_d;
    logic [33:0] sub_a;
    logic [33:0] sub_b;
    logic [34:0] diff;
    logic        ge;
    logic [33:0] rem_it;
    logic [63:0] sh_it;
    logic [29:0] root_it;

    // Working values.
    logic        out_free;
    logic        in_fire;
    logic [15:0] dmag;
    logic [15:0] qmag;
    logic [25:0] advmag;
    logic signed [41:0] mval;
    logic        uneg;
    logic        bneg;
    logic        fx;
    logic        fy;
    logic        step_x;
    logic        step_y;
    logic        sel_axis;
    logic signed [48:0] bsum;
    dist_t       bsat;
    index_t      cell_step;

    function automatic logic in_bounds(input index_t cx, input index_t cy,
                                       input index_t x0, input index_t x1,
                                       input index_t y0, input index_t y1);
        in_bounds = (cx >= x0) && (cx < x1) && (cy >= y0) && (cy < y1);
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign cell_x     = ocx_reg;
    assign cell_y     = ocy_reg;
    assign inside_res = oin_reg;
    assign point_x    = opx_reg;
    assign point_y    = opy_reg;
    assign prev_x     = oqx_reg;
    assign prev_y     = oqy_reg;

    always_comb
    begin
        unique case (state_reg)
            S_MULX:
            begin
                mul_a = 17'(dir_reg[0]);
                mul_b = 17'(dir_reg[0]);
            end
            S_MULY:
            begin
                mul_a = 17'(dir_reg[1]);
                mul_b = 17'(dir_reg[1]);
            end
            S_MADV:
            begin
                mul_a = {1'b0, um_reg};
                mul_b = {1'b0, cs_reg};
            end
            default:
            begin
                mul_a = 17'(cell_reg[axis_reg]);
                mul_b = {1'b0, cs_reg};
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb
    begin
        is_sqrt = (state_reg == S_SQRT);
        div_d   = (state_reg == S_UDIV) ? root_reg : {14'd0, um_reg};
        if (is_sqrt)
        begin
            sub_a = {rem_reg[31:0], sh_reg[63:62]};
            sub_b = {2'b00, root_reg, 2'b01};
        end
        else
        begin
            sub_a = {rem_reg[32:0], sh_reg[63]};
            sub_b = {4'd0, div_d};
        end
        diff    = {1'b0, sub_a} - {1'b0, sub_b};
        ge      = !diff[34];
        rem_it  = ge ? diff[33:0] : sub_a;
        sh_it   = is_sqrt ? {sh_reg[61:0], 2'b00} : {sh_reg[62:0], ge};
        root_it = {root_reg[28:0], ge};
    end

    // Step datapath: the axis with the nearer boundary moves, ties go to y.
    always_comb
    begin
        fx        = (unit_reg[0] == '0);
        fy        = (unit_reg[1] == '0);
        step_x    = !fx && (fy || (bnd_reg[0] < bnd_reg[1]));
        step_y    = !step_x && !fy;
        sel_axis  = !step_x;
        bsum      = 49'(bnd_reg[sel_axis]) + 49'({1'b0, cross_reg[sel_axis]});
        bsat      = (bsum > 49'(DIST_MAX)) ? DIST_MAX : bsum[47:0];
        cell_step = cell_reg[sel_axis] + (unit_reg[sel_axis][15] ? '1 : index_t'(1));
    end

    always_comb
    begin
        dmag   = dir_reg[axis_reg][15] ? 16'(-dir_reg[axis_reg]) : dir_reg[axis_reg];
        qmag   = sh_reg[15:0];
        uneg   = unit_reg[axis_reg][15];
        advmag = 26'((prod[31:0] + 32'd32) >> 6);
        mval   = (42'(prod) <<< 8) - 42'(pnt_reg[axis_reg])
                 + (uneg ? 42'sd0 : 42'({cs_reg, 8'd0}));
        bneg   = mneg_reg ^ uneg;
    end

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        sq_next        = sq_reg;
        um_next        = um_reg;
        mneg_next      = mneg_reg;
        mmag_next      = mmag_reg;
        dir_next       = dir_reg;
        unit_next      = unit_reg;
        cross_next     = cross_reg;
        bnd_next       = bnd_reg;
        adv_next       = adv_reg;
        cell_next      = cell_reg;
        pnt_next       = pnt_reg;
        prv_next       = prv_reg;
        cs_next        = cs_reg;
        xmin_next      = xmin_reg;
        xmax_next      = xmax_reg;
        ymin_next      = ymin_reg;
        ymax_next      = ymax_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ocx_next       = ocx_reg;
        ocy_next       = ocy_reg;
        oin_next       = oin_reg;
        opx_next       = opx_reg;
        opy_next       = opy_reg;
        oqx_next       = oqx_reg;
        oqy_next       = oqy_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CELL_SIZE:   cs_next   = cfg_data;
                CFG_INDEX_X_MIN: xmin_next = index_t'(signed'(cfg_data));
                CFG_INDEX_X_MAX: xmax_next = index_t'(signed'(cfg_data));
                CFG_INDEX_Y_MIN: ymin_next = index_t'(signed'(cfg_data));
                CFG_INDEX_Y_MAX: ymax_next = index_t'(signed'(cfg_data));
                default:         ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (cmd == CMD_STEP))
                begin
                    prv_next = pnt_reg;
                    pnt_next[0] = pnt_reg[0] + adv_reg[0];
                    pnt_next[1] = pnt_reg[1] + adv_reg[1];
                    if (step_x || step_y)
                    begin
                        bnd_next[sel_axis]  = bsat;
                        cell_next[sel_axis] = cell_step;
                    end
                    out_valid_next = 1'b1;
                    ocx_next = cell_next[0];
                    ocy_next = cell_next[1];
                    oin_next = in_bounds(cell_next[0], cell_next[1],
                                         xmin_reg, xmax_reg, ymin_reg, ymax_reg);
                    opx_next = pnt_next[0];
                    opy_next = pnt_next[1];
                    oqx_next = pnt_reg[0];
                    oqy_next = pnt_reg[1];
                end
                else if (in_fire)
                begin
                    dir_next[0]  = dir_x;
                    dir_next[1]  = dir_y;
                    cell_next[0] = start_cell_x;
                    cell_next[1] = start_cell_y;
                    pnt_next[0]  = start_x;
                    pnt_next[1]  = start_y;
                    prv_next[0]  = start_x;
                    prv_next[1]  = start_y;
                    state_next   = S_MULX;
                end
            end
            S_MULX:
            begin
                sq_next    = prod[31:0];
                state_next = S_MULY;
            end
            S_MULY:
            begin
                sh_next    = {sq_reg + prod[31:0], 32'd0};
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                sh_next   = sh_it;
                rem_next  = rem_it;
                root_next = root_it;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST)
                begin
                    axis_next  = 1'b0;
                    state_next = S_ULOAD;
                end
            end
            S_ULOAD:
            begin
                if (root_reg == '0)
                begin
                    // Zero direction vector: the axis is frozen.
                    unit_next[axis_reg]  = '0;
                    adv_next[axis_reg]   = '0;
                    cross_next[axis_reg] = DIST_MAX;
                    bnd_next[axis_reg]   = DIST_MAX;
                    axis_next  = 1'b1;
                    state_next = axis_reg ? S_OUT : S_ULOAD;
                end
                else
                begin
                    sh_next    = {20'd0, dmag, 28'd0} + {35'd0, root_reg[29:1]};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_UDIV;
                end
            end
            S_UDIV, S_CDIV, S_BDIV:
            begin
                sh_next  = sh_it;
                rem_next = rem_it;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    priority case (state_reg)
                        S_UDIV: state_next = S_UFIN;
                        S_CDIV:
                        begin
                            cross_next[axis_reg] = sh_it[47:0];
                            sh_next  = {1'b0, mmag_reg, 22'd0} + {49'd0, um_reg[15:1]};
                            rem_next = '0;
                            cnt_next = '0;
                            state_next = S_BDIV;
                        end
                        default: state_next = S_BFIN;
                    endcase
                end
            end
            S_UFIN:
            begin
                unit_next[axis_reg] = dir_reg[axis_reg][15] ? -qmag : qmag;
                um_next = qmag;
                if (qmag == '0)
                begin
                    // A component that rounds to zero freezes its axis.
                    adv_next[axis_reg]   = '0;
                    cross_next[axis_reg] = DIST_MAX;
                    bnd_next[axis_reg]   = DIST_MAX;
                    axis_next  = 1'b1;
                    state_next = axis_reg ? S_OUT : S_ULOAD;
                end
                else
                begin
                    state_next = S_MADV;
                end
            end
            S_MADV:
            begin
                adv_next[axis_reg] = uneg ? -coord_t'(advmag) : coord_t'(advmag);
                state_next = S_MBND;
            end
            S_MBND:
            begin
                mneg_next  = mval[41];
                mmag_next  = mval[41] ? 41'(-mval) : mval[40:0];
                sh_next    = {18'd0, cs_reg, 30'd0} + {49'd0, um_reg[15:1]};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_CDIV;
            end
            S_BFIN:
            begin
                if (bneg)
                begin
                    bnd_next[axis_reg] = (sh_reg > 64'h0000_8000_0000_0000) ? DIST_MIN
                                         : -dist_t'(sh_reg[47:0]);
                end
                else
                begin
                    bnd_next[axis_reg] = (sh_reg > 64'(DIST_MAX)) ? DIST_MAX
                                         : dist_t'(sh_reg[47:0]);
                end
                axis_next  = 1'b1;
                state_next = axis_reg ? S_OUT : S_ULOAD;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ocx_next = cell_reg[0];
                    ocy_next = cell_reg[1];
                    oin_next = in_bounds(cell_reg[0], cell_reg[1],
                                         xmin_reg, xmax_reg, ymin_reg, ymax_reg);
                    opx_next = pnt_reg[0];
                    opy_next = pnt_reg[1];
                    oqx_next = prv_reg[0];
                    oqy_next = prv_reg[1];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            cs_reg        <= 16'd32;
            xmin_reg      <= index_t'(0);
            xmax_reg      <= index_t'(64);
            ymin_reg      <= index_t'(0);
            ymax_reg      <= index_t'(64);
            for (int a = 0; a < 2; a++)
            begin
                unit_reg[a]  <= '0;
                cross_reg[a] <= '0;
                bnd_reg[a]   <= '0;
                adv_reg[a]   <= '0;
                cell_reg[a]  <= '0;
                pnt_reg[a]   <= '0;
                prv_reg[a]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            cs_reg        <= cs_next;
            xmin_reg      <= xmin_next;
            xmax_reg      <= xmax_next;
            ymin_reg      <= ymin_next;
            ymax_reg      <= ymax_next;
            unit_reg      <= unit_next;
            cross_reg     <= cross_next;
            bnd_reg       <= bnd_next;
            adv_reg       <= adv_next;
            cell_reg      <= cell_next;
            pnt_reg       <= pnt_next;
            prv_reg       <= prv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        sq_reg   <= sq_next;
        um_reg   <= um_next;
        mneg_reg <= mneg_next;
        mmag_reg <= mmag_next;
        dir_reg  <= dir_next;
        ocx_reg  <= ocx_next;
        ocy_reg  <= ocy_next;
        oin_reg  <= oin_next;
        opx_reg  <= opx_next;
        opy_reg  <= opy_next;
        oqx_reg  <= oqx_next;
        oqy_reg  <= oqy_next;
    end

endmodule

`default_nettype wire

>>> hdl/grt_checker.sv
// ============================================================================
// grt_checker
// Port-level checks on the handshakes and command timing of the ray stepper.
// ============================================================================
`default_nettype none

module grt_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        cmd,
    input wire        out_valid,
    input wire        out_ready,
    input wire [31:0] point_x
);
    import grt_pkg::*;

    // A waiting result is never dropped and its point_x never changes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_x))
        else $error("result changed while stalled");

    // A result that cannot leave blocks new commands.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // A step result appears the cycle after its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_STEP) |=> out_valid)
        else $error("step result missing");

    // A start transfer leaves the block busy and with no result right after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_START) |=> !in_ready && !out_valid)
        else $error("start did not hold the block busy");

endmodule

bind grid_ray_traversal grt_checker u_grt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point_x   (point_x)
);

`default_nettype wire
